@@ hdl/tdma_window_scheduler_core_assert.svh @@
// Assertion macros for the scheduler RTL.
// Each use expands to one labeled concurrent assertion.
`ifndef TDMA_WINDOW_SCHEDULER_CORE_ASSERT_SVH
`define TDMA_WINDOW_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define TWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tws: same-cycle check failed");

// next-cycle implication
`define TWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tws: next-cycle check failed");

`endif

@@ hdl/tws_pkg.sv @@
`default_nettype none

package tws_pkg;

    // field widths
    localparam int CFG_W    = 16;   // config registers and heard fields
    localparam int NOW_W    = 32;   // input timestamp
    localparam int CYC_W    = 18;   // cycle length and anchor
    localparam int REM_W    = 19;   // signed remaining time
    localparam int IDX_W    = 3;    // config register index
    localparam int IN_DW    = 64;   // input tdata
    localparam int OUT_DW   = 40;   // output tdata

    // config register indexes
    localparam logic [IDX_W-1:0] CFG_OWN_WINDOW  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_GAP         = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MIN_WINDOW  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_MAX_WINDOW  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_INIT_PEER   = 3'd4;

    // reset values
    localparam logic [CFG_W-1:0] RST_OWN_WINDOW = 16'd250;
    localparam logic [CFG_W-1:0] RST_GAP        = 16'd50;
    localparam logic [CFG_W-1:0] RST_MIN_WINDOW = 16'd20;
    localparam logic [CFG_W-1:0] RST_MAX_WINDOW = 16'd2000;
    localparam logic [CFG_W-1:0] RST_INIT_PEER  = 16'd250;
    localparam logic [CYC_W-1:0] RST_CYCLE      = 18'd600;

    // item kinds
    localparam logic FUNC_QUERY  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;   // latch accepted input word
        logic prep;      // apply peer length, form dividends
        logic load_div;  // load remainder lanes
        logic step;      // one remainder bit
        logic fix;       // sign fix-up of remainders
        logic emit;      // write result register, commit anchor
    } t_cmd;

    // own + peer + 2 * gap, fits 18 bits
    function automatic logic [CYC_W-1:0] cycle_sum(input logic [CFG_W-1:0] own,
                                                   input logic [CFG_W-1:0] peer,
                                                   input logic [CFG_W-1:0] gap);
        logic [CYC_W-1:0] s;
        s = CYC_W'(own) + CYC_W'(peer) + (CYC_W'(gap) << 1);
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hdl/tws_rem.sv @@
`default_nettype none

// Bit-serial always-positive remainder of a signed word by the cycle length.
module tws_rem #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire logic                         i_step,
    input  wire logic                         i_fix,
    input  wire logic [TIME_BITS-1:0]         i_dividend,
    input  wire logic [tws_pkg::CYC_W-1:0]    i_divisor,
    output logic      [tws_pkg::CYC_W-1:0]    o_result
);
    import tws_pkg::*;

    logic [TIME_BITS-1:0] r_quo;
    logic [CYC_W-1:0]     r_rem;
    logic                 r_neg;
    logic [CYC_W-1:0]     r_res;
    logic [CYC_W:0]       w_trial;
    logic [CYC_W-1:0]     n_rem;

    // restoring step: shift in next magnitude bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quo[TIME_BITS-1]};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = CYC_W'(w_trial - {1'b0, i_divisor});
        end else begin
            n_rem = w_trial[CYC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg <= i_dividend[TIME_BITS-1];
            r_quo <= i_dividend[TIME_BITS-1] ? (~i_dividend + TIME_BITS'(1)) : i_dividend;
            r_rem <= '0;
        end else if (i_step) begin
            r_quo <= r_quo << 1;
            r_rem <= n_rem;
        end
    end

    // negative dividend: remainder folds to divisor - r; zero divisor gives 0
    always_ff @(posedge i_clk) begin
        if (i_fix) begin
            if (i_divisor == '0) begin
                r_res <= '0;
            end else if (r_neg && (r_rem != '0)) begin
                r_res <= i_divisor - r_rem;
            end else begin
                r_res <= r_rem;
            end
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

@@ hdl/tws_dp.sv @@
`default_nettype none

// Datapath: config and link state, dividend forming, two remainder lanes,
// result register.
module tws_dp #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire tws_pkg::t_cmd                i_cmd,
    input  wire logic [tws_pkg::IN_DW-1:0]    i_in_data,   // now, heard len, heard rem
    input  wire logic                         i_in_func,
    input  wire logic                         i_cfg_we,
    input  wire logic [tws_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [tws_pkg::CFG_W-1:0]    i_cfg_data,
    output logic      [tws_pkg::OUT_DW-1:0]   o_out_data   // send, own rem, peer rem, acc
);
    import tws_pkg::*;

    // config and link state; the initial peer length lands directly in r_peer
    logic [CFG_W-1:0] r_own, r_gap, r_min, r_max, r_peer;
    logic [CYC_W-1:0] r_cycle, r_anchor;

    // latched item
    logic                    r_func;
    logic signed [NOW_W-1:0] r_now;
    logic [CFG_W-1:0]        r_hlen, r_hrem;
    logic                    r_ok;

    // dividends
    logic [TIME_BITS-1:0] r_x_own, r_x_peer;
    logic [TIME_BITS-1:0] w_now_t;
    logic                 w_in_bounds;

    // lane results
    logic [CYC_W-1:0] w_dt_own, w_dt_peer;

    // result word
    logic             r_send, r_acc;
    logic [REM_W-1:0] r_own_rem, r_peer_rem;
    logic [REM_W-1:0] w_own_rem, w_peer_rem;

    assign w_now_t     = TIME_BITS'(r_now);
    assign w_in_bounds = (r_hlen >= r_min) && (r_hlen <= r_max);

    // state registers: config writes, peer length on update, anchor on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own       <= RST_OWN_WINDOW;
            r_gap       <= RST_GAP;
            r_min       <= RST_MIN_WINDOW;
            r_max       <= RST_MAX_WINDOW;
            r_peer      <= RST_INIT_PEER;
            r_cycle     <= RST_CYCLE;
            r_anchor    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OWN_WINDOW: begin
                        r_own   <= i_cfg_data;
                        r_cycle <= cycle_sum(i_cfg_data, r_peer, r_gap);
                    end
                    CFG_GAP: begin
                        r_gap   <= i_cfg_data;
                        r_cycle <= cycle_sum(r_own, r_peer, i_cfg_data);
                    end
                    CFG_MIN_WINDOW: r_min <= i_cfg_data;
                    CFG_MAX_WINDOW: r_max <= i_cfg_data;
                    CFG_INIT_PEER: begin
                        r_peer      <= i_cfg_data;
                        r_cycle     <= cycle_sum(r_own, i_cfg_data, r_gap);
                    end
                    default: ;
                endcase
            end
            if (i_cmd.prep && (r_func == FUNC_UPDATE) && w_in_bounds
                && (r_hlen != r_peer)) begin
                r_peer  <= r_hlen;
                r_cycle <= cycle_sum(r_own, r_hlen, r_gap);
            end
            if (i_cmd.emit && (r_func == FUNC_UPDATE)) begin
                r_anchor <= w_dt_own;
            end
        end
    end

    // input latch and dividend forming
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_in_func;
            r_now  <= i_in_data[NOW_W-1:0];
            r_hlen <= i_in_data[NOW_W+CFG_W-1:NOW_W];
            r_hrem <= i_in_data[NOW_W+2*CFG_W-1:NOW_W+CFG_W];
        end
        if (i_cmd.prep) begin
            r_ok <= (r_func == FUNC_UPDATE) && w_in_bounds;
            if (r_func == FUNC_UPDATE) begin
                r_x_own <= w_now_t + TIME_BITS'(r_hrem) + TIME_BITS'(r_gap);
            end else begin
                r_x_own <= w_now_t - TIME_BITS'(r_anchor);
            end
            r_x_peer <= w_now_t - TIME_BITS'(r_anchor) - TIME_BITS'(r_own) - TIME_BITS'(r_gap);
        end
    end

    // two lanes share the divisor; on update the first lane yields the anchor
    tws_rem #(.TIME_BITS(TIME_BITS)) u_rem_own (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load_div),
        .i_step     (i_cmd.step),
        .i_fix      (i_cmd.fix),
        .i_dividend (r_x_own),
        .i_divisor  (r_cycle),
        .o_result   (w_dt_own)
    );

    tws_rem #(.TIME_BITS(TIME_BITS)) u_rem_peer (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load_div),
        .i_step     (i_cmd.step),
        .i_fix      (i_cmd.fix),
        .i_dividend (r_x_peer),
        .i_divisor  (r_cycle),
        .o_result   (w_dt_peer)
    );

    // remaining time in each window
    assign w_own_rem  = REM_W'(r_own) - REM_W'(w_dt_own);
    assign w_peer_rem = REM_W'(r_peer) - REM_W'(w_dt_peer);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_func == FUNC_UPDATE) begin
                r_send     <= 1'b0;
                r_own_rem  <= '0;
                r_peer_rem <= '0;
            end else begin
                r_send     <= CYC_W'(r_own) > w_dt_own;
                r_own_rem  <= w_own_rem;
                r_peer_rem <= w_peer_rem;
            end
            r_acc <= r_ok;
        end
    end

    assign o_out_data = {r_acc, r_peer_rem, r_own_rem, r_send};

endmodule

`default_nettype wire

@@ hdl/tws_ctrl.sv @@
`default_nettype none

`include "tdma_window_scheduler_core_assert.svh"

// Controller: sequences one item through the datapath, owns both handshakes.
module tws_ctrl #(
    parameter int TIME_BITS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output tws_pkg::t_cmd      o_cmd
);
    import tws_pkg::*;

    localparam int CNT_W = $clog2(TIME_BITS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_LOAD = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIX  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_cmd             w_cmd;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        w_cmd       = '0;
        o_s_tready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                w_cmd.load_in = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                w_cmd.prep = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                w_cmd.load_div = 1'b1;
                n_cnt          = CNT_W'(TIME_BITS - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                w_cmd.step = 1'b1;
                n_cnt      = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                w_cmd.fix = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                // hold until the result register is free
                if (!r_out_valid || i_m_tready) begin
                    w_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = w_cmd;

    // an accepted word always moves on to preparation
    `TWS_ASSERT_NXT(a_accept_prep, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state == S_PREP)
    // the last remainder step hands over to the fix-up
    `TWS_ASSERT_NXT(a_div_end, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt == '0), r_state == S_FIX)
    // a result is only written into a free result register
    `TWS_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, w_cmd.emit, !r_out_valid || i_m_tready)
    // a fresh result follows an emit
    `TWS_ASSERT_IMP(a_valid_src, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_EMIT)

endmodule

`default_nettype wire

@@ hdl/tdma_window_scheduler_core.sv @@
`default_nettype none

// Channel   Dir  Handshake              Payload
// s (item)  in   i_s_tvalid/o_s_tready  tdata: now, heard len, heard rem; tuser: func
// m (rslt)  out  o_m_tvalid/i_m_tready  tdata: send, own rem, peer rem, length acc
// cfg       in   i_cfg_valid/o_cfg_ready index 0..4, 16-bit data
//
// An item steps through accept, prep, lane load, divide, fix-up and emit; the divide
// runs in the bit-serial remainder lanes, which retire one dividend bit per cycle.
// Reset is synchronous, active low; it loads the register defaults, a cycle of
// 600 ms and a zero anchor.
// A result waits in the output register while the next item is accepted and
// processed; that item only stalls at its final write if the result is still held.
// The config port is always ready and is meant to be written while no item is in flight.
module tdma_window_scheduler_core #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // item input
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [tws_pkg::IN_DW-1:0]    i_s_tdata,  // now_ms[31:0], heard_peer_window[47:32],
                                                          // heard_peer_remaining[63:48]
    input  wire logic                         i_s_tuser,  // func[0]
    // result output
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic      [tws_pkg::OUT_DW-1:0]   o_m_tdata,  // send_allowed[0], own_remaining[19:1],
                                                          // peer_remaining[38:20],
                                                          // length_accepted[39]
    // config write
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [tws_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [tws_pkg::CFG_W-1:0]    i_cfg_data
);
    import tws_pkg::*;

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    tws_ctrl #(.TIME_BITS(TIME_BITS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    tws_dp #(.TIME_BITS(TIME_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_s_tdata),
        .i_in_func   (i_s_tuser),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_m_tdata)
    );

endmodule

`default_nettype wire
